// ----- sv/assert_macros.svh -----
// Assertion helper macros for the partition mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/dprm_pkg.sv -----
// ----------------------------------------------------------------------------
// dprm_pkg
// Shared types and codes for the partition request mapper.
// ----------------------------------------------------------------------------
package dprm_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;
    localparam logic [1:0] CMD_SORT  = 2'd3;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_IO  = 2'd1;
    localparam logic [1:0] ST_INV = 2'd2;
    localparam logic [1:0] ST_END = 2'd3;

    localparam logic [2:0] REG_HEADS0 = 3'd0;
    localparam logic [2:0] REG_SPT0   = 3'd1;
    localparam logic [2:0] REG_HEADS1 = 3'd2;
    localparam logic [2:0] REG_SPT1   = 3'd3;
    localparam logic [2:0] REG_DRIVES = 3'd4;

    localparam int SECTOR_BYTES = 512;
    localparam int DEVICES_PER_DRIVE = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_SORT,
        S_RDENT,
        S_DIV1,
        S_DIV2,
        S_DONE,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic do_load;
        logic sort_step;
        logic read_entry;
        logic div1_start;
        logic div2_start;
        logic finish_ok;
        logic finish_err;
        logic [1:0] err_code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_dev;
        logic [1:0] command;
        logic bad_count;
        logic bad_drive;
        logic bad_align;
        logic sort_bad;
        logic sort_last;
        logic past_end;
        logic div_busy;
    } dp_stat_t;

endpackage

// ----- sv/dprm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dprm_ctrl
// Sequencer for checks, table updates, sort passes and the divider.
// ----------------------------------------------------------------------------
module dprm_ctrl
    import dprm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     out_stall,
    output logic     out_valid,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                // closed while reset is held
                in_stall = !rst_n;
                if (in_valid && rst_n)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.bad_dev)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_IO;
                    state_next = S_OUT;
                end
                else if (stat.command == CMD_LOAD)
                begin
                    state_next = S_LOAD;
                end
                else if (stat.command == CMD_SORT)
                begin
                    if (stat.sort_bad)
                    begin
                        cmd.finish_err = 1'b1;
                        cmd.err_code = ST_IO;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SORT;
                    end
                end
                else if (stat.bad_count)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_INV;
                    state_next = S_OUT;
                end
                else if (stat.bad_drive)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_IO;
                    state_next = S_OUT;
                end
                else if (stat.bad_align)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_INV;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RDENT;
                end
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                cmd.finish_err = 1'b1;
                cmd.err_code = ST_OK;
                state_next = S_OUT;
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (stat.sort_last)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_RDENT:
            begin
                cmd.read_entry = 1'b1;
                state_next = S_DIV1;
            end
            S_DIV1:
            begin
                if (stat.past_end)
                begin
                    cmd.finish_err = 1'b1;
                    cmd.err_code = ST_END;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div1_start = 1'b1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div2_start = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.div_busy)
                begin
                    cmd.finish_ok = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dprm_dp.sv -----
// ----------------------------------------------------------------------------
// dprm_dp
// Partition table, request checks, sort compare-swap and restoring divider.
// ----------------------------------------------------------------------------
module dprm_dp
    import dprm_pkg::*;
#(
    parameter int NUM_DEVICES = 10,
    parameter int BLOCK_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [2:0]  cfg_index,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic [1:0]  command,
    input  logic [3:0]  device,
    input  logic [15:0] byte_count,
    input  logic [31:0] position,
    input  logic [31:0] raw_start,
    input  logic [31:0] raw_size,
    output logic [1:0]  status,
    output logic        drive,
    output logic [31:0] cylinder,
    output logic [7:0]  head,
    output logic [5:0]  sector,
    output logic [6:0]  sector_count,
    output logic        is_write
);

    localparam int SPB = BLOCK_BYTES / SECTOR_BYTES;
    localparam int SPB_W = $clog2(SPB);
    localparam int BLK_W = $clog2(BLOCK_BYTES);
    localparam int SEC_W = $clog2(SECTOR_BYTES);

    logic [31:0] start_reg [NUM_DEVICES];
    logic [31:0] size_reg  [NUM_DEVICES];
    logic [7:0]  heads0_reg, heads1_reg;
    logic [5:0]  spt0_reg, spt1_reg;
    logic [1:0]  drives_reg;

    logic [1:0]  cmd_reg;
    logic [3:0]  dev_reg;
    logic [15:0] count_reg;
    logic [31:0] pos_reg, rstart_reg, rsize_reg;
    logic        drv_reg;
    logic [3:0]  pass_reg;
    logic [1:0]  pair_reg;
    logic [31:0] ent_start_reg, ent_size_reg;

    // divider
    logic [31:0] quo_reg, dvd_reg;
    logic [13:0] dvs_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] cyl_reg;
    logic [7:0]  spt_sel, heads_sel;

    logic [1:0]  status_reg;
    logic [31:0] cylinder_reg;
    logic [7:0]  head_reg;
    logic [5:0]  sector_reg;
    logic        ok_reg;

    logic [3:0]  base;
    logic [3:0]  ia, ib;
    logic [31:0] rel;
    logic [32:0] rel_end;
    logic [SPB_W:0] adj;
    logic [31:0] ld_start;
    logic [14:0] trial;

    assign heads_sel = (drv_reg == 1'b0) ? heads0_reg : heads1_reg;
    assign spt_sel   = {2'b00, (drv_reg == 1'b0) ? spt0_reg : spt1_reg};
    assign base = drv_reg ? 4'(DEVICES_PER_DRIVE + 1) : 4'd1;
    // pair index for this step: three pairs per pass
    assign ia = base + {2'b00, pair_reg};
    assign ib = ia + 4'd1;
    assign rel = {{SEC_W{1'b0}}, pos_reg[31:SEC_W]};
    assign rel_end = {1'b0, rel} + 33'(SPB);

    generate
        if (SPB > 1)
        begin : g_adj
            assign adj = (rstart_reg[SPB_W-1:0] == '0) ? '0
                       : (SPB_W+1)'(SPB) - {1'b0, rstart_reg[SPB_W-1:0]};
        end
        else
        begin : g_noadj
            assign adj = '0;
        end
    endgenerate
    assign ld_start = rstart_reg + 32'(adj);
    assign trial = {rem_reg, dvd_reg[31]} - {1'b0, dvs_reg};

    assign stat.bad_dev   = (dev_reg >= 4'(NUM_DEVICES));
    assign stat.command   = cmd_reg;
    assign stat.bad_count = (count_reg != 16'(BLOCK_BYTES));
    assign stat.bad_drive = ({1'b0, drv_reg} >= drives_reg) && (drives_reg != 2'd3);
    assign stat.bad_align = (pos_reg[BLK_W-1:0] != '0);
    assign stat.sort_bad  = (32'(base) + 32'd4 > 32'(NUM_DEVICES));
    assign stat.sort_last = (pass_reg == 4'd11);
    assign stat.past_end  = (rel_end > {1'b0, ent_size_reg});
    assign stat.div_busy  = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DEVICES; i++)
            begin
                start_reg[i] <= '0;
                size_reg[i] <= '0;
            end
            heads0_reg <= 8'd1;
            spt0_reg <= 6'd17;
            heads1_reg <= 8'd1;
            spt1_reg <= 6'd17;
            drives_reg <= '0;
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            pass_reg <= '0;
            pair_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HEADS0: heads0_reg <= cfg_data;
                    REG_SPT0:   spt0_reg <= cfg_data[5:0];
                    REG_HEADS1: heads1_reg <= cfg_data;
                    REG_SPT1:   spt1_reg <= cfg_data[5:0];
                    REG_DRIVES: drives_reg <= cfg_data[1:0];
                    default:    ;
                endcase
            end
            if (cmd.capture)
            begin
                pass_reg <= '0;
                pair_reg <= '0;
            end
            if (cmd.do_load)
            begin
                start_reg[dev_reg] <= ld_start;
                size_reg[dev_reg] <= (rsize_reg > 32'(adj)) ? rsize_reg - 32'(adj) : '0;
            end
            if (cmd.sort_step)
            begin
                pass_reg <= pass_reg + 4'd1;
                pair_reg <= (pair_reg == 2'd2) ? 2'd0 : pair_reg + 2'd1;
                if ((start_reg[ia] == '0 && start_reg[ib] != '0) ||
                    (start_reg[ia] > start_reg[ib] && start_reg[ib] != '0))
                begin
                    start_reg[ia] <= start_reg[ib];
                    start_reg[ib] <= start_reg[ia];
                    size_reg[ia] <= size_reg[ib];
                    size_reg[ib] <= size_reg[ia];
                end
            end
            if (cmd.div1_start || cmd.div2_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= command;
            dev_reg <= device;
            count_reg <= byte_count;
            pos_reg <= position;
            rstart_reg <= raw_start;
            rsize_reg <= raw_size;
            drv_reg <= (device >= 4'(DEVICES_PER_DRIVE));
        end
        if (cmd.read_entry)
        begin
            ent_start_reg <= start_reg[dev_reg];
            ent_size_reg <= size_reg[dev_reg];
        end
        if (cmd.div1_start)
        begin
            // abs sector / (heads * spt)
            dvd_reg <= rel + ent_start_reg;
            dvs_reg <= 14'((heads_sel == '0) ? 8'd1 : heads_sel)
                     * 14'((spt_sel == '0) ? 6'd1 : spt_sel[5:0]);
            rem_reg <= '0;
        end
        else if (cmd.div2_start)
        begin
            // in-cylinder remainder / spt
            cyl_reg <= quo_reg;
            dvd_reg <= {18'd0, rem_reg};
            dvs_reg <= {8'd0, (spt_sel[5:0] == '0) ? 6'd1 : spt_sel[5:0]};
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (!trial[14])
            begin
                rem_reg <= trial[13:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[12:0], dvd_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.finish_err)
        begin
            status_reg <= cmd.err_code;
            ok_reg <= 1'b0;
        end
        if (cmd.finish_ok)
        begin
            status_reg <= ST_OK;
            ok_reg <= 1'b1;
            cylinder_reg <= cyl_reg;
            head_reg <= quo_reg[7:0];
            sector_reg <= rem_reg[5:0];
        end
    end

    assign status       = status_reg;
    assign drive        = ok_reg & drv_reg;
    assign cylinder     = ok_reg ? cylinder_reg : '0;
    assign head         = ok_reg ? head_reg : '0;
    assign sector       = ok_reg ? sector_reg : '0;
    assign sector_count = ok_reg ? 7'(SPB) : '0;
    assign is_write     = ok_reg & (cmd_reg == CMD_WRITE);

endmodule

// ----- sv/disk_partition_request_mapper_core.sv -----
// ----------------------------------------------------------------------------
// disk_partition_request_mapper_core
// Partition table with request checking and CHS translation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/stall): one transaction carries command, device,
//   byte_count, position, raw_start and raw_size. in_stall is low only
//   while the block is idle and out of reset, so one transaction is in
//   flight at a time.
//   Output channel (valid/stall): exactly one result per input transaction.
//   Request errors, loads and end-of-partition results need no divider;
//   a sort makes twelve compare-swap steps, and a good request runs a
//   1-bit-per-cycle restoring divider twice for 32 steps (cylinder, then
//   head/sector).
//   A new transaction is taken only after the last result is accepted.
//   Reset empties the partition table and loads the geometry defaults.
//   While out_stall is high the result holds and no new input is taken.
//   Configuration writes (cfg_we/cfg_index/cfg_data) go straight to the
//   geometry registers; write them only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module disk_partition_request_mapper_core
    import dprm_pkg::*;
#(
    parameter int NUM_DEVICES = 10,
    parameter int BLOCK_BYTES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [3:0]  device,
    input  logic [15:0] byte_count,
    input  logic [31:0] position,
    input  logic [31:0] raw_start,
    input  logic [31:0] raw_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        drive,
    output logic [31:0] cylinder,
    output logic [7:0]  head,
    output logic [5:0]  sector,
    output logic [6:0]  sector_count,
    output logic        is_write
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dprm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    dprm_dp #(
        .NUM_DEVICES (NUM_DEVICES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_index    (cfg_index),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .command      (command),
        .device       (device),
        .byte_count   (byte_count),
        .position     (position),
        .raw_start    (raw_start),
        .raw_size     (raw_size),
        .status       (status),
        .drive        (drive),
        .cylinder     (cylinder),
        .head         (head),
        .sector       (sector),
        .sector_count (sector_count),
        .is_write     (is_write)
    );

    // a result is never offered while a new transaction may enter
    `CHK_IMPL(a_excl, clk, rst_n, out_valid, in_stall, "input open while result pending")
    // an accepted transaction leaves the idle state
    `CHK_NEXT(a_acc, clk, rst_n, in_valid && !in_stall, in_stall, "accept did not start work")
    // second divider run never starts while busy
    `CHK_IMPL(a_div, clk, rst_n, cmd.div2_start, !stat.div_busy, "divider restarted while busy")

endmodule

// ----- bench/disk_partition_request_mapper_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disk_partition_request_mapper_core_tb
// Self-checking bench for the partition request mapper.
// A local model of the partition table and the CHS split predicts every
// result. A directed table runs first, then random traffic in several
// idling phases, with geometry and drive count changed between phases.
// ----------------------------------------------------------------------------
module disk_partition_request_mapper_core_tb;
    import dprm_pkg::*;

    localparam int NDEV      = 10;
    localparam int BLK_BYTES = 1024;
    localparam int SEC_PER_BLK = BLK_BYTES / SECTOR_BYTES;
    localparam int WDOG_LIMIT  = 20000;

    // one transaction on either side
    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  dev;
        logic [15:0] cnt;
        logic [31:0] pos;
        logic [31:0] rstart;
        logic [31:0] rsize;
    } req_t;

    typedef struct {
        logic [1:0]  st;
        logic        drv;
        logic [31:0] cyl;
        logic [7:0]  hd;
        logic [5:0]  sec;
        logic [6:0]  scnt;
        logic        wr;
    } chs_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [3:0]  device;
    logic [15:0] byte_count;
    logic [31:0] position;
    logic [31:0] raw_start;
    logic [31:0] raw_size;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        drive;
    logic [31:0] cylinder;
    logic [7:0]  head;
    logic [5:0]  sector;
    logic [6:0]  sector_count;
    logic        is_write;

    disk_partition_request_mapper_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .device(device), .byte_count(byte_count),
        .position(position), .raw_start(raw_start), .raw_size(raw_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .drive(drive), .cylinder(cylinder), .head(head),
        .sector(sector), .sector_count(sector_count), .is_write(is_write)
    );

    // shadow partition table and geometry
    logic [31:0] tbl_start [NDEV];
    logic [31:0] tbl_size  [NDEV];
    logic [7:0]  geo_heads [2];
    logic [5:0]  geo_spt   [2];
    logic [1:0]  geo_drives;

    chs_t pending_chs [$];
    int   errors;
    int   idle_cycles;
    int   in_idle_pct;    // sender idle chance, percent
    int   out_stall_pct;  // receiver stall chance, percent
    bit   hold_off;       // long receiver hold-off in progress

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic chs_t map_request(req_t r);
        chs_t o;
        logic [32:0] adj;
        logic [32:0] st;
        logic [31:0] rel;
        logic [31:0] abs_sec;
        logic [31:0] hds;
        logic [31:0] spt;
        logic [31:0] per_cyl;
        logic [31:0] t;
        int base;
        int drv;
        o = '{default: '0};
        if (r.dev >= NDEV)
        begin
            o.st = ST_IO;
            return o;
        end
        drv = r.dev / DEVICES_PER_DRIVE;
        if (r.cmd == CMD_LOAD)
        begin
            adj = '0;
            st = {1'b0, r.rstart};
            if (r.rstart % SEC_PER_BLK != 0)
            begin
                adj = 33'(SEC_PER_BLK - (r.rstart % SEC_PER_BLK));
                st = st + adj;
            end
            tbl_start[r.dev] = st[31:0];
            tbl_size[r.dev] = ({1'b0, r.rsize} > adj) ? r.rsize - adj[31:0] : 32'd0;
            return o;
        end
        if (r.cmd == CMD_SORT)
        begin
            base = drv * DEVICES_PER_DRIVE + 1;
            if (base + 4 > NDEV)
            begin
                o.st = ST_IO;
                return o;
            end
            for (int i = 0; i < 4; i++)
                for (int j = base; j < base + 3; j++)
                    if ((tbl_start[j] == 0 && tbl_start[j+1] != 0) ||
                        (tbl_start[j] > tbl_start[j+1] && tbl_start[j+1] != 0))
                    begin
                        t = tbl_start[j]; tbl_start[j] = tbl_start[j+1];
                        tbl_start[j+1] = t;
                        t = tbl_size[j]; tbl_size[j] = tbl_size[j+1];
                        tbl_size[j+1] = t;
                    end
            return o;
        end
        if (r.cnt != BLK_BYTES)
        begin
            o.st = ST_INV;
            return o;
        end
        // drive count of three still means two drives
        if (drv >= geo_drives)
        begin
            o.st = ST_IO;
            return o;
        end
        if (r.pos % BLK_BYTES != 0)
        begin
            o.st = ST_INV;
            return o;
        end
        rel = r.pos / SECTOR_BYTES;
        if (64'(rel) + SEC_PER_BLK > 64'(tbl_size[r.dev]))
        begin
            o.st = ST_END;
            return o;
        end
        abs_sec = rel + tbl_start[r.dev];
        hds = (geo_heads[drv] == 0) ? 32'd1 : 32'(geo_heads[drv]);
        spt = (geo_spt[drv] == 0) ? 32'd1 : 32'(geo_spt[drv]);
        per_cyl = hds * spt;
        o.st = ST_OK;
        o.drv = drv[0];
        o.cyl = abs_sec / per_cyl;
        o.hd = 8'((abs_sec % per_cyl) / spt);
        o.sec = 6'(abs_sec % spt);
        o.scnt = 7'(SEC_PER_BLK);
        o.wr = (r.cmd == CMD_WRITE);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result check at each accepted output transaction
    always @(posedge clk)
    begin
        chs_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chs.size() == 0)
            begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end
            else
            begin
                e = pending_chs.pop_front();
                if (status !== e.st) report_mismatch("status", 32'(status), 32'(e.st));
                if (drive !== e.drv) report_mismatch("drive", 32'(drive), 32'(e.drv));
                if (cylinder !== e.cyl) report_mismatch("cylinder", cylinder, e.cyl);
                if (head !== e.hd) report_mismatch("head", 32'(head), 32'(e.hd));
                if (sector !== e.sec) report_mismatch("sector", 32'(sector), 32'(e.sec));
                if (sector_count !== e.scnt)
                    report_mismatch("sector_count", 32'(sector_count), 32'(e.scnt));
                if (is_write !== e.wr)
                    report_mismatch("is_write", 32'(is_write), 32'(e.wr));
            end
        end
    end

    // receiver stall: random, or held high during a hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= hold_off || ($urandom_range(99) < out_stall_pct);
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_HEADS0: geo_heads[0] = val;
            REG_SPT0:   geo_spt[0] = val[5:0];
            REG_HEADS1: geo_heads[1] = val;
            REG_SPT1:   geo_spt[1] = val[5:0];
            REG_DRIVES: geo_drives = val[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one transaction and hold it until accepted; valid stays high
    // afterwards until the next call or until drain/pause drops it
    task automatic send_req(req_t r);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= r.cmd;
        device <= r.dev;
        byte_count <= r.cnt;
        position <= r.pos;
        raw_start <= r.rstart;
        raw_size <= r.rsize;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_chs.push_back(map_request(r));
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_chs.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic req_t rand_req();
        req_t r;
        int pick;
        r.cmd = 2'($urandom_range(3));
        r.dev = ($urandom_range(15) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
        pick = $urandom_range(9);
        r.cnt = (pick < 8) ? 16'(BLK_BYTES) : 16'($urandom);
        // mostly aligned positions inside small partitions
        pick = $urandom_range(9);
        if (pick < 6)
            r.pos = 32'($urandom_range(40)) * BLK_BYTES;
        else if (pick < 8)
            r.pos = $urandom & ~32'(BLK_BYTES - 1);
        else
            r.pos = $urandom;
        r.rstart = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(200000));
        r.rsize = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(100));
        // load and sort are less frequent than requests
        if (r.cmd >= CMD_LOAD && $urandom_range(2) != 0)
            r.cmd = 2'($urandom_range(1));
        return r;
    endfunction

    // directed table: expected status typed in where obvious
    typedef struct {
        req_t r;
        bit   chk;
        logic [1:0] st;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic add_row(logic [1:0] c, logic [3:0] d, logic [15:0] n,
                           logic [31:0] p, logic [31:0] s, logic [31:0] z,
                           bit chk, logic [1:0] st);
        dir_row_t row;
        row.r = '{c, d, n, p, s, z};
        row.chk = chk;
        row.st = st;
        dir_rows.push_back(row);
    endtask

    initial
    begin
        req_t r;
        chs_t e;
        int n;
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_HEADS0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_READ;
        device = '0;
        byte_count = '0;
        position = '0;
        raw_start = '0;
        raw_size = '0;
        for (int i = 0; i < NDEV; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i] = '0;
        end
        geo_heads = '{8'd1, 8'd1};
        geo_spt = '{6'd17, 6'd17};
        geo_drives = 2'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: no drives, empty table
        add_row(CMD_READ, 4'd0, 16'(BLK_BYTES), 32'd0, 32'd0, 32'd0, 1'b1, ST_IO);
        add_row(CMD_READ, 4'd15, 16'(BLK_BYTES), 32'd0, 32'd0, 32'd0, 1'b1, ST_IO);
        add_row(CMD_LOAD, 4'd10, 16'd0, 32'd0, 32'd5, 32'd5, 1'b1, ST_IO);
        add_row(CMD_SORT, 4'd9, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK);
        add_row(CMD_WRITE, 4'd1, 16'hFFFF, 32'd0, 32'd0, 32'd0, 1'b1, ST_INV);
        add_row(CMD_READ, 4'd1, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_INV);
        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].r);
            e = pending_chs[$];
            if (e.st !== dir_rows[i].st)
                report_mismatch("table status", 32'(e.st), 32'(dir_rows[i].st));
        end
        drain();
        dir_rows.delete();

        cfg_write(REG_DRIVES, 8'd3);
        cfg_write(REG_HEADS0, 8'd0);
        cfg_write(REG_SPT0, 8'd0);
        cfg_write(REG_HEADS1, 8'd255);
        cfg_write(REG_SPT1, 8'd63);
        // loads: unaligned start, start wrap, size shrink to zero, extremes
        add_row(CMD_LOAD, 4'd1, 16'd0, 32'd0, 32'd7, 32'd100, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd2, 16'd0, 32'd0, 32'hFFFF_FFFF, 32'd1, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd3, 16'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd4, 16'd0, 32'd0, 32'd4, 32'd50, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd6, 16'd0, 32'd0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd9, 16'd0, 32'd0, 32'd101, 32'd0, 1'b1, ST_OK);
        add_row(CMD_LOAD, 4'd0, 16'd0, 32'd0, 32'hAAAA_5554, 32'h5555_AAAA, 1'b1, ST_OK);
        add_row(CMD_SORT, 4'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK);
        add_row(CMD_SORT, 4'd7, 16'd0, 32'd0, 32'd0, 32'd0, 1'b1, ST_OK);
        add_row(CMD_READ, 4'd1, 16'(BLK_BYTES), 32'd512, 32'd0, 32'd0, 1'b1, ST_INV);
        add_row(CMD_READ, 4'd1, 16'(BLK_BYTES), 32'hFFFF_FC00, 32'd0, 32'd0, 1'b1, ST_END);
        add_row(CMD_READ, 4'd1, 16'(BLK_BYTES), 32'd0, 32'd0, 32'd0, 1'b0, ST_OK);
        add_row(CMD_WRITE, 4'd2, 16'(BLK_BYTES), 32'd1024, 32'd0, 32'd0, 1'b0, ST_OK);
        add_row(CMD_WRITE, 4'd3, 16'(BLK_BYTES), 32'hFFFF_F800, 32'd0, 32'd0, 1'b0, ST_OK);
        add_row(CMD_READ, 4'd6, 16'(BLK_BYTES), 32'h5555_5400, 32'd0, 32'd0, 1'b0, ST_OK);
        add_row(CMD_WRITE, 4'd0, 16'(BLK_BYTES), 32'h2AAA_AC00, 32'd0, 32'd0, 1'b0, ST_OK);
        add_row(CMD_READ, 4'd9, 16'(BLK_BYTES), 32'd0, 32'd0, 32'd0, 1'b1, ST_END);
        foreach (dir_rows[i])
        begin
            send_req(dir_rows[i].r);
            e = pending_chs[$];
            if (dir_rows[i].chk && e.st !== dir_rows[i].st)
                report_mismatch("table status", 32'(e.st), 32'(dir_rows[i].st));
        end
        drain();

        // random phases: sender idle pct, receiver stall pct
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 66; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 66; end
                3: begin in_idle_pct = 23; out_stall_pct = 23; end
                4: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            cfg_write(REG_DRIVES, 8'($urandom_range(3)));
            cfg_write(REG_HEADS0, (ph == 4) ? 8'd255 : 8'($urandom_range(255)));
            cfg_write(REG_SPT0, (ph == 4) ? 8'd63 : 8'($urandom_range(63)));
            cfg_write(REG_HEADS1, (ph == 4) ? 8'd1 : 8'($urandom_range(255)));
            cfg_write(REG_SPT1, (ph == 4) ? 8'd1 : 8'($urandom_range(63)));
            if (ph == 2)
            begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            n = 0;
            while (n < 275)
            begin
                r = rand_req();
                send_req(r);
                n++;
                // a pause until the block is empty
                if (ph == 3 && n == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_chs.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
